// File: hdl/pitch_class_key_finder_assert.svh
// assertion macros shared by the key finder modules
`ifndef PITCH_CLASS_KEY_FINDER_ASSERT_SVH
`define PITCH_CLASS_KEY_FINDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCKF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key finder check failed");

// next-cycle implication, checked outside reset
`define PCKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key finder check failed");

`endif

// File: hdl/pckf_pkg.sv
// shared constants, command and status types and the key profile table
package pckf_pkg;

  localparam int PITCH_CLASSES   = 12;
  localparam int KEY_COUNT       = 24;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int COEF_BITS_DEF   = 16;
  localparam int NOTE_W          = 16;
  localparam int KEY_W           = 5;
  localparam int BIN_W           = 4;
  localparam int PROFILE_W       = 10;

  localparam logic REQ_NOTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic             clear;
    logic             capture;
    logic             bin_calc;
    logic             update;
    logic             scan_start;
    logic             issue;
    logic             issue_first;
    logic             issue_last;
    logic [KEY_W-1:0] key;
    logic [BIN_W-1:0] bin;
    logic             load_out;
  } pckf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_positive;
  } pckf_status_t;

  // centered, normalized major and minor profiles for tonic c, 8 fraction bits
  function automatic logic signed [PROFILE_W-1:0] profile_word(input logic [KEY_W-1:0] idx);
    logic signed [PROFILE_W-1:0] w;
    unique case (idx)
      5'd0:    w = 10'sd168;
      5'd1:    w = -10'sd73;
      5'd2:    w = 10'sd0;
      5'd3:    w = -10'sd67;
      5'd4:    w = 10'sd53;
      5'd5:    w = 10'sd36;
      5'd6:    w = -10'sd56;
      5'd7:    w = 10'sd100;
      5'd8:    w = -10'sd64;
      5'd9:    w = 10'sd10;
      5'd10:   w = -10'sd70;
      5'd11:   w = -10'sd35;
      5'd12:   w = 10'sd168;
      5'd13:   w = -10'sd66;
      5'd14:   w = -10'sd12;
      5'd15:   w = 10'sd107;
      5'd16:   w = -10'sd71;
      5'd17:   w = -10'sd11;
      5'd18:   w = -10'sd75;
      5'd19:   w = 10'sd67;
      5'd20:   w = 10'sd17;
      5'd21:   w = -10'sd65;
      5'd22:   w = -10'sd24;
      5'd23:   w = -10'sd34;
      default: w = 10'sd0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/pckf_ctrl.sv
// sequencer: accepts transactions, steps through keys and bins, hands off results
module pckf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pckf_pkg::pckf_cmd_t cmd,
  input  pckf_pkg::pckf_status_t status
);
  import pckf_pkg::*;
  `include "pitch_class_key_finder_assert.svh"

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_BIN    = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RESULT = 6'b100000
  } pckf_state_t;

  pckf_state_t      state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_bin, last_key, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign last_bin  = (bin_r == BIN_W'(PITCH_CLASSES - 1));
  assign last_key  = (key_r == KEY_W'(KEY_COUNT - 1));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.key       = key_r;
    cmd.bin       = bin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_BIN;
          end
        end
      end
      ST_BIN: begin
        cmd.bin_calc = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.scan_start = 1'b1;
        key_nxt        = '0;
        bin_nxt        = '0;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue       = 1'b1;
        cmd.issue_first = (bin_r == '0);
        cmd.issue_last  = last_bin;
        if (last_bin) begin
          bin_nxt = '0;
          key_nxt = key_r + KEY_W'(1);
          if (last_key) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          bin_nxt = bin_r + BIN_W'(1);
        end
      end
      ST_DRAIN: begin
        if (status.scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_r       <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PCKF_ASSERT_NOW(a_done_in_drain, clk, rst_n, status.scan_done, state_r == ST_DRAIN)
  `PCKF_ASSERT_NEXT(a_last_issue_drains, clk, rst_n, cmd.issue && cmd.issue_last && last_key, state_r == ST_DRAIN)
  `PCKF_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.load_out, out_valid_r && state_r == ST_IDLE)

endmodule

// File: hdl/pckf_datapath.sv
// histogram, pipelined multiply-accumulate over key profiles and best-key tracking
module pckf_datapath #(
  parameter int COUNT_BITS = pckf_pkg::COUNT_BITS_DEF,
  parameter int COEF_BITS  = pckf_pkg::COEF_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pckf_pkg::pckf_cmd_t               cmd,
  output pckf_pkg::pckf_status_t            status,
  input  logic signed [pckf_pkg::NOTE_W-1:0] note_number,
  output logic [pckf_pkg::KEY_W-1:0]        key_index
);
  import pckf_pkg::*;
  `include "pitch_class_key_finder_assert.svh"

  localparam int TOT_W   = COUNT_BITS + 4;
  localparam int CEN_W   = COUNT_BITS + 5;
  localparam int PROD_W  = CEN_W + COEF_BITS;
  localparam int ACC_W   = PROD_W + 4;
  localparam int X_W     = NOTE_W - 2;
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 17;
  localparam int QP_W    = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = 16'hAAAB;

  logic [COUNT_BITS-1:0] hist_r [PITCH_CLASSES];
  logic [TOT_W-1:0]      total_r;
  logic [NOTE_W-1:0]     mag_r;
  logic [BIN_W-1:0]      bin_r;

  // magnitude mod 12 = 4 * ((mag / 4) mod 3) + mag mod 4
  logic [X_W-1:0]  x_div4;
  logic [QP_W-1:0] qprod;
  logic [X_W-1:0]  q3, r3;
  assign x_div4 = mag_r[NOTE_W-1:2];
  assign qprod  = QP_W'(x_div4) * QP_W'(RECIP3);
  assign q3     = X_W'({qprod[QP_W-1:RECIP_SHIFT], 1'b0}) + X_W'(qprod[QP_W-1:RECIP_SHIFT]);
  assign r3     = x_div4 - q3;

  logic [BIN_W-1:0]      rd_bin;
  logic [COUNT_BITS-1:0] h_rd;
  assign rd_bin = cmd.issue ? cmd.bin : bin_r;
  assign h_rd   = hist_r[rd_bin];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < PITCH_CLASSES; i++) begin
        hist_r[i] <= '0;
      end
      total_r <= '0;
    end else if (cmd.update && (h_rd != '1)) begin
      hist_r[bin_r] <= h_rd + COUNT_BITS'(1);
      total_r       <= total_r + TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r <= note_number[NOTE_W-1] ? NOTE_W'(~note_number + 1'b1) : NOTE_W'(note_number);
    end
    if (cmd.bin_calc) begin
      bin_r <= {r3[1:0], mag_r[1:0]};
    end
  end

  // stage a: centered count and profile word
  logic                    mode;
  logic [BIN_W-1:0]        tonic, pos;
  logic [KEY_W-1:0]        pos_full, rom_idx;
  logic [TOT_W-1:0]        h12;
  logic signed [CEN_W-1:0] centered_nxt;

  assign mode     = (cmd.key >= KEY_W'(PITCH_CLASSES));
  assign tonic    = mode ? BIN_W'(cmd.key - KEY_W'(PITCH_CLASSES)) : cmd.key[BIN_W-1:0];
  assign pos_full = KEY_W'(cmd.bin) + KEY_W'(PITCH_CLASSES) - KEY_W'(tonic);
  assign pos      = (pos_full >= KEY_W'(PITCH_CLASSES)) ?
                    BIN_W'(pos_full - KEY_W'(PITCH_CLASSES)) : pos_full[BIN_W-1:0];
  assign rom_idx  = mode ? KEY_W'(PITCH_CLASSES) + KEY_W'(pos) : KEY_W'(pos);
  assign h12      = TOT_W'({h_rd, 3'b000}) + TOT_W'({h_rd, 2'b00});
  assign centered_nxt = $signed({1'b0, h12}) - $signed({1'b0, total_r});

  logic                        a_valid_r, b_valid_r;
  logic                        a_first_r, a_last_r, b_first_r, b_last_r;
  logic [KEY_W-1:0]            a_key_r, b_key_r;
  logic signed [CEN_W-1:0]     centered_r;
  logic signed [COEF_BITS-1:0] coef_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]     acc_r, best_r, sum;
  logic [KEY_W-1:0]            best_key_r, out_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= cmd.issue;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_first_r  <= cmd.issue_first;
    a_last_r   <= cmd.issue_last;
    a_key_r    <= cmd.key;
    centered_r <= centered_nxt;
    coef_r     <= COEF_BITS'(profile_word(rom_idx));
    b_first_r  <= a_first_r;
    b_last_r   <= a_last_r;
    b_key_r    <= a_key_r;
    prod_r     <= centered_r * coef_r;
  end

  // stage c: accumulate one key's score, compare at its last bin
  assign sum = b_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      acc_r <= sum;
    end
    if (cmd.scan_start) begin
      best_r     <= '0;
      best_key_r <= '0;
    end else if (b_valid_r && b_last_r && (sum > best_r)) begin
      best_r     <= sum;
      best_key_r <= b_key_r;
    end
    if (cmd.load_out) begin
      out_key_r <= best_key_r;
    end
  end

  assign status.scan_done     = b_valid_r && b_last_r && (b_key_r == KEY_W'(KEY_COUNT - 1));
  assign status.best_positive = (best_r > '0);
  assign key_index            = out_key_r;

  `PCKF_ASSERT_NOW(a_bin_in_range, clk, rst_n, cmd.update, bin_r < BIN_W'(PITCH_CLASSES))
  `PCKF_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, total_r == '0)
  `PCKF_ASSERT_NOW(a_best_key_range, clk, rst_n, cmd.load_out, best_key_r < KEY_W'(KEY_COUNT) && (status.best_positive || best_key_r == '0))

endmodule

// File: hdl/pitch_class_key_finder.sv
// Pitch-class key finder: each note transaction bumps a saturating 12-bin pitch-class
// histogram and triggers a full rescan of the 24 major/minor profiles on one shared
// multiply-accumulate pipeline, one bin per cycle; a note passes through accept, bin,
// update, 288 multiply-accumulate steps, drain and result. A clear transaction is taken
// in the idle state and returns nothing. The result is held in an output register, so
// the next transaction is taken while it waits.
module pitch_class_key_finder #(
  parameter int COUNT_BITS = pckf_pkg::COUNT_BITS_DEF,
  parameter int COEF_BITS  = pckf_pkg::COEF_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic signed [pckf_pkg::NOTE_W-1:0] in_note_number,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pckf_pkg::KEY_W-1:0]         out_key_index
);
  import pckf_pkg::*;

  pckf_cmd_t    cmd;
  pckf_status_t status;

  pckf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status)
  );

  pckf_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .note_number (in_note_number),
    .key_index   (out_key_index)
  );

endmodule

// File: verif/key_score_checker.sv
// scoreboard for the key finder: mirrors the histogram, predicts each key and checks results
module key_score_checker #(
  parameter int COUNT_BITS = pckf_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_req_type,
  input  logic signed [pckf_pkg::NOTE_W-1:0] in_note_number,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [pckf_pkg::KEY_W-1:0]         out_key_index,
  output int                                 fail_count,
  output int                                 keys_pending,
  output int                                 keys_checked,
  output int                                 notes_taken,
  output int                                 clears_taken,
  output int                                 saturated_notes,
  output logic [pckf_pkg::KEY_COUNT-1:0]     keys_hit
);
  import pckf_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // centered, normalized major then minor profile for tonic c, 8 fraction bits
  int kk_weight [KEY_COUNT] = '{
    168, -73, 0, -67, 53, 36, -56, 100, -64, 10, -70, -35,
    168, -66, -12, 107, -71, -11, -75, 67, 17, -65, -24, -34
  };

  logic [COUNT_BITS-1:0] class_count [PITCH_CLASSES];
  logic [KEY_W-1:0]      expected_keys [$];

  int                    fails;
  int                    checked;
  int                    notes;
  int                    clears;
  int                    sat;
  logic [KEY_COUNT-1:0]  seen = '0;

  // score = sum (12*h - total) * coef, the histogram variance is common to all keys
  function automatic logic [KEY_W-1:0] strongest_key();
    longint total;
    longint score;
    longint best;
    int     tonic;
    int     base;
    logic [KEY_W-1:0] pick;
    total = 0;
    best  = 0;
    pick  = '0;
    for (int i = 0; i < PITCH_CLASSES; i++) total += longint'(class_count[i]);
    for (int k = 0; k < KEY_COUNT; k++) begin
      tonic = k % PITCH_CLASSES;
      base  = (k >= PITCH_CLASSES) ? PITCH_CLASSES : 0;
      score = 0;
      for (int i = 0; i < PITCH_CLASSES; i++) begin
        score += (longint'(class_count[i]) * PITCH_CLASSES - total) *
                 kk_weight[base + (i + PITCH_CLASSES - tonic) % PITCH_CLASSES];
      end
      // strict compare keeps the lowest index on ties and key 0 when nothing is positive
      if (score > best) begin
        best = score;
        pick = KEY_W'(k);
      end
    end
    return pick;
  endfunction

  always @(posedge clk) begin : track
    int               bin;
    logic [KEY_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < PITCH_CLASSES; i++) class_count[i] = '0;
      expected_keys.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_CLEAR) begin
          for (int i = 0; i < PITCH_CLASSES; i++) class_count[i] = '0;
          clears++;
        end else begin
          bin = (in_note_number < 0) ? (-int'(in_note_number)) % PITCH_CLASSES
                                     : int'(in_note_number) % PITCH_CLASSES;
          if (class_count[bin] == COUNT_MAX) sat++;
          else class_count[bin] = class_count[bin] + 1'b1;
          expected_keys.push_back(strongest_key());
          notes++;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $error("key_index: no result expected, actual %0d", out_key_index);
          fails++;
        end else begin
          want = expected_keys.pop_front();
          if (out_key_index !== want) begin
            $error("key_index mismatch: expected %0d, actual %0d", want, out_key_index);
            fails++;
          end
          checked++;
          seen[want] = 1'b1;
        end
      end
    end
    fail_count      <= fails;
    keys_pending    <= expected_keys.size();
    keys_checked    <= checked;
    notes_taken     <= notes;
    clears_taken    <= clears;
    saturated_notes <= sat;
    keys_hit        <= seen;
  end

endmodule

// File: verif/tb_pitch_class_key_finder.sv
// testbench top for the pitch-class key finder: stimulus, output pacing and verdict
module tb_pitch_class_key_finder;
  import pckf_pkg::*;

  // narrow counts so bin saturation is reachable in a short run
  localparam int HIST_BITS      = 8;
  localparam int SAT_NOTES      = 300;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_req_type = REQ_NOTE;
  logic signed [NOTE_W-1:0] in_note_number = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [KEY_W-1:0]         out_key_index;

  int                       fail_count;
  int                       keys_pending;
  int                       keys_checked;
  int                       notes_taken;
  int                       clears_taken;
  int                       saturated_notes;
  logic [KEY_COUNT-1:0]     keys_hit;

  int                       burst_left = 0;
  int                       random_items = 0;
  int                       quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pitch_class_key_finder #(
    .COUNT_BITS(HIST_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_note_number (in_note_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index)
  );

  key_score_checker #(
    .COUNT_BITS(HIST_BITS)
  ) key_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_note_number  (in_note_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_index   (out_key_index),
    .fail_count      (fail_count),
    .keys_pending    (keys_pending),
    .keys_checked    (keys_checked),
    .notes_taken     (notes_taken),
    .clears_taken    (clears_taken),
    .saturated_notes (saturated_notes),
    .keys_hit        (keys_hit)
  );

  // a note of the given pitch class, mostly in a playable range, sometimes anywhere
  function automatic logic signed [NOTE_W-1:0] class_note(input int pc);
    int mag;
    if ($urandom_range(0, 3) != 0) mag = pc + 12 * $urandom_range(2, 10);
    else mag = pc + 12 * $urandom_range(0, (32767 - pc) / 12);
    if ($urandom_range(0, 1) == 1) return NOTE_W'(-mag);
    return NOTE_W'(mag);
  endfunction

  // notes that follow a scale, leaning on tonic and fifth, with some noise
  function automatic logic signed [NOTE_W-1:0] phrase_note(input int tonic, input bit minor_mode);
    int major_steps [7] = '{0, 2, 4, 5, 7, 9, 11};
    int minor_steps [7] = '{0, 2, 3, 5, 7, 8, 10};
    int roll;
    int degree;
    int pc;
    roll = $urandom_range(0, 99);
    if (roll < 5) return NOTE_W'($urandom);
    if (roll < 15) begin
      pc = $urandom_range(0, 11);
    end else begin
      if (roll < 35) degree = 0;
      else if (roll < 45) degree = 4;
      else degree = $urandom_range(0, 6);
      pc = (tonic + (minor_mode ? minor_steps[degree] : major_steps[degree])) % 12;
    end
    return class_note(pc);
  endfunction

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid       <= 1'b0;
      in_req_type    <= 1'($urandom_range(0, 1));
      in_note_number <= NOTE_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // bursts of random length with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 8);
        default: gap = $urandom_range(1, 350);
      endcase
      idle_for(gap);
    end
    burst_left--;
  endtask

  task automatic offer(input logic req, input logic signed [NOTE_W-1:0] note);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_note_number <= note;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (keys_pending != 0);
  endtask

  initial begin : stimulus
    logic signed [NOTE_W-1:0] extreme_notes [7] = '{
      16'sh8000, 16'sh7fff, 16'shffff, 16'sd1, 16'sd0, 16'sh8001, 16'sd24
    };
    int pc;
    int tonic;
    int phrase_len;
    bit minor_mode;
    bit drained;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // clear on an empty histogram, then one note per class ends on a flat histogram
    offer(REQ_CLEAR, 16'sd0);
    for (int i = 0; i < 12; i++) begin
      offer(REQ_NOTE, (i % 2 == 1) ? NOTE_W'(-(i + 12)) : NOTE_W'(i));
    end
    offer(REQ_CLEAR, 16'sh7fff);
    foreach (extreme_notes[i]) offer(REQ_NOTE, extreme_notes[i]);
    offer(REQ_CLEAR, 16'sh8000);

    // one class hammered past its count limit
    pc = $urandom_range(0, 11);
    for (int n = 0; n < SAT_NOTES; n++) begin
      pace();
      if (n % 40 == 39) offer(REQ_NOTE, class_note((pc + $urandom_range(1, 11)) % 12));
      else offer(REQ_NOTE, class_note(pc));
    end
    pace();
    offer(REQ_CLEAR, NOTE_W'($urandom));

    // phrases in random keys, usually cleared between, sometimes piled on
    drained = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      tonic      = $urandom_range(0, 11);
      minor_mode = 1'($urandom_range(0, 1));
      phrase_len = $urandom_range(3, 60);
      for (int n = 0; n < phrase_len; n++) begin
        pace();
        offer(REQ_NOTE, phrase_note(tonic, minor_mode));
        random_items++;
      end
      if (!drained && random_items >= RANDOM_ITEMS / 2) begin
        drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        pace();
        offer(REQ_CLEAR, NOTE_W'($urandom));
        random_items++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d notes and %0d clears, %0d keys checked, %0d of 24 keys reported",
             notes_taken, clears_taken, keys_checked, $countones(keys_hit));
    $display("%0d notes hit a full bin; output held off %0d cycles once, input drained once",
             saturated_notes, LONG_HOLD);
    if (fail_count == 0) begin
      $display("** pitch_class_key_finder: PASSED **");
    end else begin
      $display("** pitch_class_key_finder: FAILED **");
    end
    $finish;
  end

  // output side: changing stall patterns plus one long hold-off
  initial begin : receiver
    int  run_left;
    int  mode;
    int  period;
    int  duty;
    int  phase;
    int  hold_left;
    bit  held;
    run_left  = 0;
    mode      = 0;
    period    = 1;
    duty      = 0;
    phase     = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(20, 600);
        period   = $urandom_range(2, 9);
        duty     = $urandom_range(1, period - 1);
      end
      run_left--;
      phase = (phase + 1) % period;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && keys_checked >= 60) begin
        held      = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) != 0);
          default: out_stall <= (phase < duty);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** pitch_class_key_finder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pckf_pkg.sv
hdl/pckf_ctrl.sv
hdl/pckf_datapath.sv
hdl/pitch_class_key_finder.sv
verif/key_score_checker.sv
verif/tb_pitch_class_key_finder.sv
